/* src/lmap_pkg.sv */
// ----------------------------------------------------------------------------
// lmap_pkg
// Shared constants for the load moving average and peak block.
// ----------------------------------------------------------------------------
package lmap_pkg;

    localparam int WINDOW_DEFAULT = 60;
    localparam int SAMPLE_W       = 8;
    localparam int S_TDATA_W      = 8;
    localparam int M_TDATA_W      = 24;

endpackage

/* src/load_moving_average_and_peak_top.sv */
// ----------------------------------------------------------------------------
// load_moving_average_and_peak_top
// Moving average over the last WINDOW load samples, plus the running peak.
// ----------------------------------------------------------------------------
// Input stream: one 8-bit load sample per transaction on s_tdata.
// Output stream: one transaction per sample on m_tdata carrying the sample,
// the peak since reset and floor(window sum / WINDOW).
// An accepted sample first enters the update stage, which writes the ring
// slot and updates the running sum and peak; the output stage then divides
// the sum by WINDOW into the output register, which raises m_tvalid.
// Throughput is one sample per cycle while the output is taken; the sample
// ring is a RAM read one slot ahead of the write position, so each accepted
// sample does one read and one write.
// Reset (aresetn low, synchronous) clears the sum, peak and write position,
// and clears the per-slot valid bits so unwritten ring slots read as zero;
// no clearing pass is needed and the block accepts input right after reset.
// When m_tready is low the output register holds; the update stage still
// takes one more sample, then s_tready drops until the output is taken.
// ----------------------------------------------------------------------------
module load_moving_average_and_peak_top #(
    parameter int WINDOW = lmap_pkg::WINDOW_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lmap_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] load_sample
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lmap_pkg::M_TDATA_W-1:0] m_tdata   // [7:0] load_now,
                                                     // [15:8] load_peak,
                                                     // [23:16] load_average
);

    localparam int SW      = lmap_pkg::SAMPLE_W;
    localparam int POS_W   = $clog2(WINDOW);
    localparam int SUM_W   = $clog2(WINDOW * ((1 << SW) - 1) + 1);
    // floor(sum / WINDOW) by reciprocal multiply, exact for any SUM_W-bit sum
    localparam int DIV_SH  = SUM_W + $clog2(WINDOW);
    localparam int RECIP_W = SUM_W + 2;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << DIV_SH) + WINDOW - 1) / WINDOW);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [WINDOW-1:0] slot_valid_reg;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [SW-1:0]     peak_reg, peak_next;

    logic              a_valid_reg;
    logic [SW-1:0]     a_sample_reg;
    logic [SW-1:0]     a_peak_reg;
    logic [SUM_W-1:0]  a_sum_reg;

    logic              m_valid_reg;
    logic [SW-1:0]     m_now_reg;
    logic [SW-1:0]     m_peak_reg;
    logic [SW-1:0]     m_avg_reg;

    logic              s_accept;
    logic              b_load;
    logic [SW-1:0]     sample;
    logic [SW-1:0]     ram_rd_data;
    logic [SW-1:0]     oldest;
    logic [POS_W-1:0]  rd_addr;
    logic [PROD_W-1:0] avg_prod;

    assign sample   = s_tdata[SW-1:0];
    assign b_load   = !m_valid_reg || m_tready;
    assign s_tready = !a_valid_reg || b_load;
    assign s_accept = s_tvalid && s_tready;

    assign pos_next = (pos_reg == POS_W'(WINDOW - 1)) ? '0 : pos_reg + POS_W'(1);
    assign rd_addr  = s_accept ? pos_next : pos_reg;
    assign oldest   = slot_valid_reg[pos_reg] ? ram_rd_data : '0;

    assign sum_next  = sum_reg - SUM_W'(oldest) + SUM_W'(sample);
    assign peak_next = (sample > peak_reg) ? sample : peak_reg;

    assign avg_prod  = PROD_W'(a_sum_reg) * PROD_W'(RECIP);

    lmap_ram #(
        .WIDTH (SW),
        .DEPTH (WINDOW)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (s_accept),
        .wr_addr (pos_reg),
        .wr_data (sample),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            slot_valid_reg <= '0;
            sum_reg        <= '0;
            peak_reg       <= '0;
            a_valid_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (s_accept) begin
                pos_reg                 <= pos_next;
                slot_valid_reg[pos_reg] <= 1'b1;
                sum_reg                 <= sum_next;
                peak_reg                <= peak_next;
                a_valid_reg             <= 1'b1;
            end else if (b_load) begin
                a_valid_reg <= 1'b0;
            end
            if (b_load) begin
                m_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_sample_reg <= sample;
            a_peak_reg   <= peak_next;
            a_sum_reg    <= sum_next;
        end
        if (b_load && a_valid_reg) begin
            m_now_reg  <= a_sample_reg;
            m_peak_reg <= a_peak_reg;
            m_avg_reg  <= SW'(avg_prod >> DIV_SH);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_avg_reg, m_peak_reg, m_now_reg};

endmodule

/* src/lmap_ram.sv */
// ----------------------------------------------------------------------------
// lmap_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lmap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* src/lmap_checker.sv */
// ----------------------------------------------------------------------------
// lmap_checker
// Port-level checks for the load moving average and peak block.
// ----------------------------------------------------------------------------
module lmap_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [lmap_pkg::M_TDATA_W-1:0] m_tdata
);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output transaction changed");

    a_peak_ge_now: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:8] >= m_tdata[7:0])
        else $error("peak below current sample");

    a_avg_le_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:16] <= m_tdata[15:8])
        else $error("average above peak");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind load_moving_average_and_peak_top lmap_checker u_lmap_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
